[src/tmac_pkg.sv]
// Package for the moving-average temperature converter.
// Holds the shared widths, constants, register indexes and queue item type.
// No dependencies.
`timescale 1ns / 1ps

package tmac_pkg;

    localparam int WINDOW_LEN = 5;
    localparam int ADC_BITS   = 12;
    localparam int REG_BITS   = 12;
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = ADC_BITS + $clog2(WINDOW_LEN);

    // The window mean is formed as (sum * AVG_RECIP) >> AVG_SHIFT, which is exact
    // for every sum below WINDOW_LEN * 2**ADC_BITS.
    localparam int AVG_SHIFT  = SUM_W + 3;
    localparam int AVG_RECIP  = (2 ** AVG_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int RECIP_W    = AVG_SHIFT - 1;

    // Fixed-point conversion: 880 = 55 * 16, 1584 = 55 * 1.8 * 16,
    // 480 = 30 * 16 and 1376 = (30 * 1.8 + 32) * 16.
    localparam int SCALE_C    = 880;
    localparam int SCALE_F    = 1584;
    localparam int OFFSET_C   = 480;
    localparam int OFFSET_F   = 1376;

    // Numerator |d| * SCALE_F + |s| / 2 fits in NUM_W bits.
    localparam int NUM_W      = 23;
    localparam int RES_W      = NUM_W + 2;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int TEMP_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_30C = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_85C = CFG_IDX_W'(1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             full;
    } tmac_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } tmac_state_t;

endpackage

[src/tmac_front.sv]
// Front end: takes samples, keeps the sample window, running sum and fill count.
// Depends on tmac_pkg.
`timescale 1ns / 1ps

module tmac_front
    import tmac_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ADC_BITS-1:0] s_adc_sample,
    output logic                push,
    output tmac_item_t          push_item,
    input  logic                queue_full
);

    logic [ADC_BITS-1:0] win_reg [WINDOW_LEN];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    // The oldest sample leaves the sum as the new one enters it.
    assign sum_next  = sum_reg + SUM_W'(s_adc_sample) - SUM_W'(win_reg[WINDOW_LEN-1]);
    assign fill_next = (fill_reg < FILL_W'(WINDOW_LEN)) ? fill_reg + FILL_W'(1) : fill_reg;

    assign push_item.sum  = sum_next;
    assign push_item.full = (fill_next == FILL_W'(WINDOW_LEN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            fill_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (push) begin
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            win_reg[0] <= s_adc_sample;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule

[src/tmac_queue.sv]
// Short queue between the front end and the conversion back end.
// Depends on tmac_pkg.
`timescale 1ns / 1ps

module tmac_queue
    import tmac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  tmac_item_t push_item,
    output logic       full,
    input  logic       pop,
    output tmac_item_t pop_item,
    output logic       not_empty
);

    tmac_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + QCNT_W'(1)))
        else $error("queue push lost");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !do_push)
        else $error("push into full queue");

endmodule

[src/tmac_back.sv]
// Back end: mean of the window, two-point calibration by iterative division,
// Fahrenheit conversion, saturation and the output register. Depends on tmac_pkg.
`timescale 1ns / 1ps

module tmac_back
    import tmac_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_avail,
    input  tmac_item_t                 item,
    output logic                       pop,
    input  logic [REG_BITS-1:0]        cal_30c,
    input  logic [REG_BITS-1:0]        cal_85c,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ADC_BITS-1:0]        m_avg_raw,
    output logic signed [TEMP_W-1:0]   m_temp_c_q4,
    output logic signed [TEMP_W-1:0]   m_temp_f_q4,
    output logic                       m_avg_valid,
    output logic                       m_cal_error
);

    tmac_state_t state_reg, state_next;

    logic [SUM_W-1:0]    sum_reg;
    logic                full_reg;
    logic [ADC_BITS-1:0] avg_reg;
    logic [REG_BITS-1:0] mag_d_reg;
    logic [REG_BITS-1:0] mag_s_reg;
    logic                neg_reg;
    logic                err_reg;
    logic [NUM_W-1:0]    num_c_reg;
    logic [NUM_W-1:0]    num_f_reg;
    logic [REG_BITS-1:0] rem_c_reg;
    logic [REG_BITS-1:0] rem_f_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                         out_valid_reg;
    logic [ADC_BITS-1:0]          out_avg_reg;
    logic signed [TEMP_W-1:0]     out_c_reg;
    logic signed [TEMP_W-1:0]     out_f_reg;
    logic                         out_full_reg;
    logic                         out_err_reg;

    logic [SUM_W+RECIP_W-1:0] avg_prod;
    logic signed [REG_BITS:0] diff_d;
    logic signed [REG_BITS:0] diff_s;
    logic [NUM_W-1:0]         half_s;
    logic [NUM_W-1:0]         num_c_step;
    logic [NUM_W-1:0]         num_f_step;
    logic [REG_BITS-1:0]      rem_c_step;
    logic [REG_BITS-1:0]      rem_f_step;
    logic signed [TEMP_W-1:0] temp_c;
    logic signed [TEMP_W-1:0] temp_f;
    logic                     out_free;
    logic                     load_out;

    // One restoring division step: shifts in the next numerator bit and
    // appends one quotient bit.
    function automatic logic [REG_BITS+NUM_W-1:0] div_step(
        input logic [REG_BITS-1:0] rem,
        input logic [NUM_W-1:0]    num,
        input logic [REG_BITS-1:0] den
    );
        logic [REG_BITS:0] trial;
        logic              take;
        logic [REG_BITS:0] diff;
        trial = {rem, num[NUM_W-1]};
        take  = (trial >= {1'b0, den});
        diff  = trial - {1'b0, den};
        div_step = {take ? diff[REG_BITS-1:0] : trial[REG_BITS-1:0],
                    num[NUM_W-2:0], take};
    endfunction

    // Applies the sign, adds the offset and clips to the 16-bit range.
    function automatic logic signed [TEMP_W-1:0] finish(
        input logic [NUM_W-1:0] q,
        input logic             neg,
        input int               offset
    );
        logic signed [RES_W-1:0] mag;
        logic signed [RES_W-1:0] val;
        mag = $signed({2'b00, q});
        val = (neg ? -mag : mag) + RES_W'(offset);
        if (val > RES_W'(2 ** (TEMP_W - 1) - 1)) begin
            finish = {1'b0, {(TEMP_W-1){1'b1}}};
        end else if (val < -$signed(RES_W'(2 ** (TEMP_W - 1)))) begin
            finish = {1'b1, {(TEMP_W-1){1'b0}}};
        end else begin
            finish = val[TEMP_W-1:0];
        end
    endfunction

    assign avg_prod = SUM_W'(sum_reg) * RECIP_W'(AVG_RECIP);
    assign diff_d   = $signed({1'b0, avg_reg}) - $signed({1'b0, cal_30c});
    assign diff_s   = $signed({1'b0, cal_85c}) - $signed({1'b0, cal_30c});
    assign half_s   = NUM_W'(mag_s_reg >> 1);

    assign {rem_c_step, num_c_step} = div_step(rem_c_reg, num_c_reg, mag_s_reg);
    assign {rem_f_step, num_f_step} = div_step(rem_f_reg, num_f_reg, mag_s_reg);

    assign temp_c = err_reg ? '0 : finish(num_c_reg, neg_reg, OFFSET_C);
    assign temp_f = err_reg ? '0 : finish(num_f_reg, neg_reg, OFFSET_F);

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_avail) begin
                    pop        = 1'b1;
                    state_next = ST_AVG;
                end
            end
            ST_AVG:  state_next = ST_PREP;
            ST_PREP: state_next = (cal_30c == cal_85c) ? ST_DONE : ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sum_reg  <= item.sum;
                full_reg <= item.full;
            end
            ST_AVG: begin
                avg_reg <= full_reg ? avg_prod[AVG_SHIFT +: ADC_BITS] : '0;
            end
            ST_PREP: begin
                mag_d_reg <= diff_d[REG_BITS] ? REG_BITS'(-diff_d) : diff_d[REG_BITS-1:0];
                mag_s_reg <= diff_s[REG_BITS] ? REG_BITS'(-diff_s) : diff_s[REG_BITS-1:0];
                neg_reg   <= diff_d[REG_BITS] ^ diff_s[REG_BITS];
                err_reg   <= (cal_30c == cal_85c);
            end
            ST_MUL: begin
                num_c_reg <= NUM_W'(mag_d_reg) * NUM_W'(SCALE_C) + half_s;
                num_f_reg <= NUM_W'(mag_d_reg) * NUM_W'(SCALE_F) + half_s;
                rem_c_reg <= '0;
                rem_f_reg <= '0;
                cnt_reg   <= '0;
            end
            ST_DIV: begin
                num_c_reg <= num_c_step;
                num_f_reg <= num_f_step;
                rem_c_reg <= rem_c_step;
                rem_f_reg <= rem_f_step;
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_avg_reg  <= avg_reg;
            out_c_reg    <= temp_c;
            out_f_reg    <= temp_f;
            out_full_reg <= full_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_avg_raw   = out_avg_reg;
    assign m_temp_c_q4 = out_c_reg;
    assign m_temp_f_q4 = out_f_reg;
    assign m_avg_valid = out_full_reg;
    assign m_cal_error = out_err_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_err_reg) |-> (out_c_reg == '0 && out_f_reg == '0))
        else $error("calibration error with nonzero temperature");

    a_partial_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_full_reg) |-> (out_avg_reg == '0))
        else $error("mean reported before window full");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == ST_AVG))
        else $error("item taken outside idle");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(NUM_W)))
        else $error("division count overrun");

endmodule

[src/temp_moving_average_convert_core.sv]
// Top level of the moving-average temperature converter.
// Depends on tmac_pkg, tmac_front, tmac_queue and tmac_back.
`timescale 1ns / 1ps

// Each accepted sample gives exactly one result transaction: the truncated mean of
// the last five samples (zero, with m_avg_valid low, until five have arrived) and
// the calibrated Celsius and Fahrenheit readings in signed sixteenths of a degree,
// saturated to 16 bits. Equal calibration points raise m_cal_error and force both
// temperatures to zero. The back end divides by the calibration span in two parallel
// restoring dividers, Celsius and Fahrenheit, one quotient bit a cycle each, and
// takes the next sample only once the last result is in the output register. With
// equal calibration points the dividers are skipped. A two-entry queue behind the
// input lets samples be taken while a result waits on m_ready.
// Calibration registers are written through cfg_we, cfg_index and cfg_data and
// must only change while no sample is in flight.

module temp_moving_average_convert_core
    import tmac_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ADC_BITS-1:0]       s_adc_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ADC_BITS-1:0]       m_avg_raw,
    output logic signed [TEMP_W-1:0]  m_temp_c_q4,
    output logic signed [TEMP_W-1:0]  m_temp_f_q4,
    output logic                      m_avg_valid,
    output logic                      m_cal_error,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data
);

    logic [REG_BITS-1:0] cal_30c_reg;
    logic [REG_BITS-1:0] cal_85c_reg;

    logic       push;
    tmac_item_t push_item;
    logic       queue_full;
    logic       pop;
    tmac_item_t pop_item;
    logic       queue_avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_30c_reg <= '0;
            cal_85c_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CAL_30C: cal_30c_reg <= cfg_data;
                CFG_CAL_85C: cal_85c_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    tmac_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    tmac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_avail)
    );

    tmac_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_avail  (queue_avail),
        .item        (pop_item),
        .pop         (pop),
        .cal_30c     (cal_30c_reg),
        .cal_85c     (cal_85c_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_avg_raw   (m_avg_raw),
        .m_temp_c_q4 (m_temp_c_q4),
        .m_temp_f_q4 (m_temp_f_q4),
        .m_avg_valid (m_avg_valid),
        .m_cal_error (m_cal_error)
    );

endmodule

[test/testbench.sv]
// Self-checking testbench for temp_moving_average_convert_core.
// Drives samples and calibration writes and checks every reading against an in-bench
// predictor or a hand-worked value. Depends on tmac_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import tmac_pkg::*;

    localparam int     CLK_HALF    = 5;
    localparam int     RUN_LIMIT   = 500000;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     SETTLE_WAIT = 4;
    localparam int     RAND_PHASES = 7;
    localparam int     PHASE_ITEMS = 204;
    localparam longint C_GAIN      = 880;
    localparam longint F_GAIN      = 1584;
    localparam longint C_BASE      = 480;
    localparam longint F_BASE      = 1376;
    localparam longint Q4_MAX      = 32767;
    localparam longint Q4_MIN      = -32768;

    localparam logic [ADC_BITS-1:0]  ADC_MAX     = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic [ADC_BITS-1:0]      avg;
        logic signed [TEMP_W-1:0] temp_c;
        logic signed [TEMP_W-1:0] temp_f;
        logic                     valid;
        logic                     err;
    } reading_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [REG_BITS-1:0]   value;
        bit                    typed;
        reading_t              want;
    } stim_row_t;

    // Readings that can be worked out by hand.
    localparam reading_t FILLING   = '{12'd0, 16'sd480, 16'sd1376, 1'b0, 1'b0};
    localparam reading_t FULL_HOT  = '{12'd4095, 16'sd1360, 16'sd2960, 1'b1, 1'b0};
    localparam reading_t FULL_COLD = '{12'd0, 16'sd480, 16'sd1376, 1'b1, 1'b0};
    localparam reading_t ERR_COLD  = '{12'd0, 16'sd0, 16'sd0, 1'b1, 1'b1};
    localparam reading_t ERR_WARM  = '{12'd819, 16'sd0, 16'sd0, 1'b1, 1'b1};

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [ADC_BITS-1:0]       s_adc_sample;
    logic                      m_valid;
    logic                      m_ready;
    logic [ADC_BITS-1:0]       m_avg_raw;
    logic signed [TEMP_W-1:0]  m_temp_c_q4;
    logic signed [TEMP_W-1:0]  m_temp_f_q4;
    logic                      m_avg_valid;
    logic                      m_cal_error;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [REG_BITS-1:0]       cfg_data;

    // Shadow copy of the converter state.
    logic [ADC_BITS-1:0]  window_shadow [WINDOW_LEN];
    int                   fill_shadow;
    logic [REG_BITS-1:0]  cal30_shadow;
    logic [REG_BITS-1:0]  cal85_shadow;

    reading_t   pending_readings [$];
    stim_row_t  stim_rows [$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;
    bit         idle_on = 1'b1;
    int         stall_left = 0;
    reading_t   got;
    reading_t   want;

    temp_moving_average_convert_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_avg_raw    (m_avg_raw),
        .m_temp_c_q4  (m_temp_c_q4),
        .m_temp_f_q4  (m_temp_f_q4),
        .m_avg_valid  (m_avg_valid),
        .m_cal_error  (m_cal_error),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Division rounded to nearest, ties away from zero.
    function automatic longint round_div(input longint num, input longint den);
        longint n;
        longint d;
        longint q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n + d / 2) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp_q4(input longint v);
        if (v > Q4_MAX) return TEMP_W'(Q4_MAX);
        if (v < Q4_MIN) return TEMP_W'(Q4_MIN);
        return TEMP_W'(v);
    endfunction

    // Shifts one sample into the shadow window and returns the reading it gives.
    function automatic reading_t convert_sample(input logic [ADC_BITS-1:0] sample);
        reading_t r;
        int       sum;
        longint   d;
        longint   s;
        for (int i = WINDOW_LEN - 1; i > 0; i--) begin
            window_shadow[i] = window_shadow[i - 1];
        end
        window_shadow[0] = sample;
        if (fill_shadow < WINDOW_LEN) fill_shadow++;
        r = '0;
        if (fill_shadow >= WINDOW_LEN) begin
            sum = 0;
            foreach (window_shadow[i]) sum += int'(window_shadow[i]);
            r.avg = ADC_BITS'(sum / WINDOW_LEN);
            r.valid = 1'b1;
        end
        if (cal30_shadow == cal85_shadow) begin
            r.err = 1'b1;
        end else begin
            d = longint'(r.avg) - longint'(cal30_shadow);
            s = longint'(cal85_shadow) - longint'(cal30_shadow);
            r.temp_c = clamp_q4(round_div(d * C_GAIN, s) + C_BASE);
            r.temp_f = clamp_q4(round_div(d * F_GAIN, s) + F_BASE);
        end
        return r;
    endfunction

    function automatic void add_sample(input logic [ADC_BITS-1:0] v, input bit typed,
                                       input reading_t r);
        stim_rows.push_back('{ROW_SAMPLE, CFG_CAL_30C, v, typed, r});
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [REG_BITS-1:0] v);
        stim_rows.push_back('{ROW_REG, idx, v, 1'b0, reading_t'('0)});
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(input logic [ADC_BITS-1:0] v, input bit typed,
                               input reading_t r);
        reading_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_adc_sample = v;
        do @(posedge aclk); while (!s_ready);
        predicted = convert_sample(v);
        pending_readings.push_back(typed ? r : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge aclk);
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_BITS-1:0] v);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_CAL_30C) cal30_shadow = v;
        else if (idx == CFG_CAL_85C) cal85_shadow = v;
    endtask

    task automatic set_phase_cal(input int phase);
        logic [REG_BITS-1:0] lo;
        logic [REG_BITS-1:0] hi;
        case (phase % 6)
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = REG_BITS'($urandom);
                hi = REG_BITS'($urandom);
            end
            2: begin
                lo = REG_BITS'($urandom);
                hi = lo;
            end
            3: begin
                lo = '1;
                hi = '0;
            end
            4: begin
                lo = REG_BITS'($urandom_range(0, 4000));
                hi = lo + REG_BITS'($urandom_range(1, 40));
            end
            default: begin
                lo = REG_BITS'($urandom_range(200, 1500));
                hi = REG_BITS'($urandom_range(2500, 3900));
            end
        endcase
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_CAL_30C, lo);
            write_reg(CFG_CAL_85C, hi);
        end else begin
            write_reg(CFG_CAL_85C, hi);
            write_reg(CFG_CAL_30C, lo);
        end
        if ($urandom_range(0, 2) == 0) begin
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                      REG_BITS'($urandom));
        end
    endtask

    // Three in eight samples land between the calibration points, where the readings stay unsaturated.
    function automatic logic [ADC_BITS-1:0] pick_sample();
        int unsigned lo;
        int unsigned hi;
        lo = 32'(cal30_shadow);
        hi = 32'(cal85_shadow);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ADC_MAX;
            2, 3, 4: return ADC_BITS'($urandom_range(hi, lo));
            default: return ADC_BITS'($urandom);
        endcase
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_adc_sample = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_CAL_30C;
        cfg_data = '0;
        foreach (window_shadow[i]) window_shadow[i] = '0;
        fill_shadow = 0;
        cal30_shadow = '0;
        cal85_shadow = '1;

        // Filling window, then all-high and all-low windows at reset calibration.
        add_sample(ADC_MAX, 1'b1, FILLING);
        add_sample('0, 1'b1, FILLING);
        add_sample(ADC_MAX, 1'b1, FILLING);
        add_sample('0, 1'b1, FILLING);
        repeat (4) add_sample(ADC_MAX, 1'b0, '0);
        add_sample(ADC_MAX, 1'b1, FULL_HOT);
        repeat (4) add_sample('0, 1'b0, '0);
        add_sample('0, 1'b1, FULL_COLD);
        // Equal calibration points.
        add_reg(CFG_CAL_30C, 12'd2048);
        add_reg(CFG_CAL_85C, 12'd2048);
        add_sample('0, 1'b1, ERR_COLD);
        add_sample(ADC_MAX, 1'b1, ERR_WARM);
        // Reversed span, and writes to unused indexes that must be ignored.
        add_reg(CFG_CAL_30C, '1);
        add_reg(CFG_CAL_85C, '0);
        add_reg(CFG_SPARE_A, 12'h5a5);
        add_reg(CFG_SPARE_B, 12'ha5a);
        add_sample(12'd2000, 1'b0, '0);
        add_sample(ADC_MAX, 1'b0, '0);
        add_sample('0, 1'b0, '0);
        // One-count spans drive both temperatures into saturation.
        add_reg(CFG_CAL_30C, 12'd0);
        add_reg(CFG_CAL_85C, 12'd1);
        add_sample(ADC_MAX, 1'b0, '0);
        add_sample(12'h800, 1'b0, '0);
        add_reg(CFG_CAL_30C, 12'd1);
        add_reg(CFG_CAL_85C, 12'd0);
        add_sample(ADC_MAX, 1'b0, '0);
        add_sample('0, 1'b0, '0);

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_REG) begin
                write_reg(stim_rows[i].index, stim_rows[i].value);
            end else begin
                send_sample(ADC_BITS'(stim_rows[i].value), stim_rows[i].typed,
                            stim_rows[i].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == RAND_PHASES - 1) idle_on = 1'b0;
            set_phase_cal(p);
            repeat (PHASE_ITEMS) send_sample(pick_sample(), 1'b0, '0);
        end

        s_valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side back-pressure in bursts.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = '{m_avg_raw, m_temp_c_q4, m_temp_f_q4, m_avg_valid, m_cal_error};
            if (pending_readings.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected transaction avg=%0d c=%0d f=%0d valid=%0b err=%0b",
                         $time, got.avg, got.temp_c, got.temp_f, got.valid, got.err);
            end else begin
                want = pending_readings.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    $display("%0t: mismatch expected avg=%0d c=%0d f=%0d valid=%0b err=%0b",
                             $time, want.avg, want.temp_c, want.temp_f, want.valid, want.err);
                    $display("%0t:          actual   avg=%0d c=%0d f=%0d valid=%0b err=%0b",
                             $time, got.avg, got.temp_c, got.temp_f, got.valid, got.err);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

[temp_moving_average_convert_core.f]
src/tmac_pkg.sv
src/tmac_front.sv
src/tmac_queue.sv
src/tmac_back.sv
src/temp_moving_average_convert_core.sv
test/testbench.sv
